>>> src/scaled_sprite_blit_blend_unit_defines.svh
// ----------------------------------------------------------------------------
// scaled sprite blitter assertion macros
// shared property templates, sampled on clk_i and disabled during reset
// ----------------------------------------------------------------------------
`ifndef SCALED_SPRITE_BLIT_BLEND_UNIT_DEFINES_SVH
`define SCALED_SPRITE_BLIT_BLEND_UNIT_DEFINES_SVH

// same-cycle implication
`define SSBB_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SSBB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/ssbb_pkg.sv
// ----------------------------------------------------------------------------
// scaled sprite blitter package
// beat types, register indexes and color constants
// ----------------------------------------------------------------------------
package ssbb_pkg;

  // default geometry
  localparam int DEF_TEXTURE_SIZE  = 64;
  localparam int DEF_SCREEN_WIDTH  = 320;
  localparam int DEF_SCREEN_HEIGHT = 200;

  // field widths
  localparam int PIXEL_W     = 10;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 11;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_ALPHA = 3'd4;

  // beat kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  // color constants
  localparam logic [8:0]  ALPHA_ONE   = 9'd256;
  localparam logic [31:0] ALPHA_MASK  = 32'hFF00_0000;
  localparam logic [31:0] RGB_MASK    = 32'h00FF_FFFF;
  localparam logic [31:0] RGB_MIN     = 32'h0008_0808;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

  // request / load beat
  typedef struct packed {
    logic                kind;
    logic [11:0]         texel_index;
    logic [31:0]         texel_value;
    logic [PIXEL_W-1:0]  pixel_x;
    logic [PIXEL_W-1:0]  pixel_y;
    logic [31:0]         dest_pixel;
  } in_beat_t;

  // framebuffer write beat
  typedef struct packed {
    logic        write_enable;
    logic [15:0] write_address;
    logic [31:0] write_color;
  } out_beat_t;

endpackage

>>> src/scaled_sprite_blit_blend_unit.sv
// ----------------------------------------------------------------------------
// scaled sprite blit and blend unit
// nearest-neighbor scaled sprite blitter with clipping, color key and blend
// ----------------------------------------------------------------------------
// One beat in, one beat out: a texel load (kind 0) or a pixel request (kind 1)
// each give exactly one output beat, in order, at one beat per clock unless
// out_ready_i stalls the pipe. The pipe holds an entry register, a restoring
// divider that settles one quotient bit per stage for both texture
// coordinates, a single-port texture memory stage and a blend and output
// register. Loads travel down the same pipe and write the texture memory at
// the read stage, so a request always sees every load sent before it. The
// texture memory has no reset; each texel must be loaded before any request
// maps onto it. Registers may only be written while the pipe is empty.

`include "scaled_sprite_blit_blend_unit_defines.svh"

module scaled_sprite_blit_blend_unit #(
  parameter int TEXTURE_SIZE  = ssbb_pkg::DEF_TEXTURE_SIZE,
  parameter int SCREEN_WIDTH  = ssbb_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = ssbb_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [ssbb_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ssbb_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // input beats
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  ssbb_pkg::in_beat_t                  in_data_i,
  // output beats
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ssbb_pkg::out_beat_t                 out_data_o
);

  localparam int TEX_ENTRIES = TEXTURE_SIZE * TEXTURE_SIZE;
  localparam int AW = $clog2(TEX_ENTRIES);
  localparam int QW = $clog2(TEXTURE_SIZE);
  localparam int PW = ssbb_pkg::PIXEL_W + $clog2(TEXTURE_SIZE + 1);
  localparam int RW = PW + 1;

  // payload carried through entry and divider stages
  typedef struct packed {
    logic          is_req;
    logic          load_ok;
    logic          hit;
    logic [AW-1:0] idx;
    logic [31:0]   data;
    logic [10:0]   fx;
    logic [10:0]   fy;
    logic [PW-1:0] rem_x;
    logic [PW-1:0] rem_y;
    logic [QW-1:0] q_x;
    logic [QW-1:0] q_y;
  } div_t;

  // configuration registers
  logic signed [10:0] dest_x_q, dest_y_q;
  logic [9:0]         dest_w_q, dest_h_q;
  logic [8:0]         blend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_x_q <= '0;
      dest_y_q <= '0;
      dest_w_q <= 10'd64;
      dest_h_q <= 10'd64;
      blend_q  <= ssbb_pkg::ALPHA_ONE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ssbb_pkg::CFG_DEST_X:      dest_x_q <= cfg_wdata_i;
        ssbb_pkg::CFG_DEST_Y:      dest_y_q <= cfg_wdata_i;
        ssbb_pkg::CFG_DEST_WIDTH:  dest_w_q <= cfg_wdata_i[9:0];
        ssbb_pkg::CFG_DEST_HEIGHT: dest_h_q <= cfg_wdata_i[9:0];
        ssbb_pkg::CFG_BLEND_ALPHA: blend_q  <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  // pipe valids, enables and payload; index 0 is the entry register
  logic [QW:0] v_q;
  logic [QW:0] en;
  div_t        div_q [QW+1];
  div_t        s0_d;
  logic        m_en;
  logic        o_en;

  // entry: clip checks, screen position and scaled dividends
  logic [11:0] fx_s, fy_s;
  logic        in_sprite, on_x, on_y, is_pix;

  always_comb begin
    is_pix    = (in_data_i.kind == ssbb_pkg::KIND_PIXEL);
    fx_s      = {dest_x_q[10], dest_x_q} + {2'b00, in_data_i.pixel_x};
    fy_s      = {dest_y_q[10], dest_y_q} + {2'b00, in_data_i.pixel_y};
    in_sprite = (in_data_i.pixel_x < dest_w_q) && (in_data_i.pixel_y < dest_h_q);
    on_x      = !fx_s[11] && (fx_s[10:0] < 11'(SCREEN_WIDTH));
    on_y      = !fy_s[11] && (fy_s[10:0] < 11'(SCREEN_HEIGHT));

    s0_d.is_req  = is_pix;
    s0_d.load_ok = 32'(in_data_i.texel_index) < TEX_ENTRIES;
    s0_d.hit     = is_pix && in_sprite && on_x && on_y;
    s0_d.idx     = AW'(in_data_i.texel_index);
    s0_d.data    = is_pix ? in_data_i.dest_pixel : in_data_i.texel_value;
    s0_d.fx      = fx_s[10:0];
    s0_d.fy      = fy_s[10:0];
    s0_d.rem_x   = PW'(in_data_i.pixel_x) * PW'(TEXTURE_SIZE);
    s0_d.rem_y   = PW'(in_data_i.pixel_y) * PW'(TEXTURE_SIZE);
    s0_d.q_x     = '0;
    s0_d.q_y     = '0;
  end

  assign en[0]      = !v_q[0] || en[1 > QW ? QW : 1];
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en[0]) begin
      v_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      div_q[0] <= s0_d;
    end
  end

  // divider stages, one quotient bit of each coordinate per stage
  for (genvar k = 1; k <= QW; k++) begin : g_div
    localparam int Sh = QW - k;
    logic [RW-1:0] sub_x, sub_y;
    div_t          nxt;

    if (k == QW) begin : g_last
      assign en[k] = !v_q[k] || m_en;
    end else begin : g_mid
      assign en[k] = !v_q[k] || en[k+1];
    end

    always_comb begin
      sub_x = {1'b0, div_q[k-1].rem_x} - (RW'(dest_w_q) << Sh);
      sub_y = {1'b0, div_q[k-1].rem_y} - (RW'(dest_h_q) << Sh);
      nxt   = div_q[k-1];
      if (!sub_x[RW-1]) begin
        nxt.rem_x = sub_x[PW-1:0];
      end
      if (!sub_y[RW-1]) begin
        nxt.rem_y = sub_y[PW-1:0];
      end
      nxt.q_x = (div_q[k-1].q_x << 1) | QW'(!sub_x[RW-1]);
      nxt.q_y = (div_q[k-1].q_y << 1) | QW'(!sub_y[RW-1]);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        div_q[k] <= nxt;
      end
    end
  end

  // texture memory stage: loads write, requests read
  logic [31:0]   tex_mem_q [TEX_ENTRIES];
  logic [AW-1:0] rd_addr;
  logic [21:0]   scr_addr;
  logic          mem_wr;
  logic          m_v_q, m_hit_q;
  logic [15:0]   m_addr_q;
  logic [31:0]   m_dst_q;
  logic [31:0]   texel_q;

  assign m_en     = !m_v_q || o_en;
  assign rd_addr  = AW'(div_q[QW].q_y) * AW'(TEXTURE_SIZE) + AW'(div_q[QW].q_x);
  assign scr_addr = 22'(div_q[QW].fy) * 22'(SCREEN_WIDTH) + 22'(div_q[QW].fx);
  assign mem_wr   = v_q[QW] && !div_q[QW].is_req && div_q[QW].load_ok;

  always_ff @(posedge clk_i) begin
    if (m_en) begin
      if (mem_wr) begin
        tex_mem_q[div_q[QW].idx] <= div_q[QW].data;
      end else begin
        texel_q <= tex_mem_q[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (m_en) begin
      m_v_q <= v_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_en) begin
      m_hit_q  <= div_q[QW].is_req && div_q[QW].hit;
      m_addr_q <= scr_addr[15:0];
      m_dst_q  <= div_q[QW].data;
    end
  end

  // per-channel weighted mix, floored
  function automatic logic [7:0] mix_channel(input logic [7:0] s, input logic [7:0] d,
                                             input logic [8:0] a);
    logic [16:0] acc;
    acc = 17'(d) * 17'(ssbb_pkg::ALPHA_ONE - a) + 17'(s) * 17'(a);
    return acc[15:8];
  endfunction

  // color key, blend and output register
  logic                skip;
  logic [31:0]         color;
  ssbb_pkg::out_beat_t out_d;
  ssbb_pkg::out_beat_t out_q;
  logic                out_v_q;

  always_comb begin
    skip = ((texel_q & ssbb_pkg::ALPHA_MASK) == '0) ||
           ((texel_q & ssbb_pkg::RGB_MASK) < ssbb_pkg::RGB_MIN);
    if (blend_q >= ssbb_pkg::ALPHA_ONE) begin
      color = texel_q;
    end else begin
      color = {ssbb_pkg::ALPHA_OPAQUE,
               mix_channel(texel_q[23:16], m_dst_q[23:16], blend_q),
               mix_channel(texel_q[15:8],  m_dst_q[15:8],  blend_q),
               mix_channel(texel_q[7:0],   m_dst_q[7:0],   blend_q)};
    end
    out_d.write_enable  = m_hit_q && !skip;
    out_d.write_address = out_d.write_enable ? m_addr_q : '0;
    out_d.write_color   = out_d.write_enable ? color : '0;
  end

  assign o_en = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (o_en) begin
      out_v_q <= m_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // assertions
  `SSBB_ASSERT_IMPLY(a_no_write_zero,
    out_v_q && !out_q.write_enable,
    out_q.write_address == '0 && out_q.write_color == '0,
    "beat without write carries nonzero address or color")
  `SSBB_ASSERT_IMPLY(a_addr_on_screen,
    out_v_q && out_q.write_enable,
    32'(out_q.write_address) < SCREEN_WIDTH * SCREEN_HEIGHT,
    "write address beyond the screen")
  `SSBB_ASSERT_IMPLY(a_blend_opaque,
    out_v_q && out_q.write_enable && blend_q < ssbb_pkg::ALPHA_ONE,
    out_q.write_color[31:24] == ssbb_pkg::ALPHA_OPAQUE,
    "blended write is not opaque")
  `SSBB_ASSERT_NEXT(a_mem_stage_hold,
    m_v_q && !m_en,
    m_v_q && $stable(m_addr_q) && $stable(m_hit_q),
    "memory stage changed while stalled")

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// scaled sprite blit and blend unit testbench
// Drives texel loads and pixel requests through the valid/ready input channel
// and checks every framebuffer write beat against a local model of the
// scaler, clipper, color key and blend. A short directed table is followed by
// random phases, each with a fresh register setting, most with random idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int TEX         = ssbb_pkg::DEF_TEXTURE_SIZE;
  localparam int TEX_ENTRIES = TEX * TEX;
  localparam int SCR_W       = ssbb_pkg::DEF_SCREEN_WIDTH;
  localparam int SCR_H       = ssbb_pkg::DEF_SCREEN_HEIGHT;
  localparam int PIPE_LAT    = $clog2(TEX) + 3;
  localparam int ITEM_TARGET = 950;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IW          = ssbb_pkg::CFG_IDX_W;
  localparam int DW          = ssbb_pkg::CFG_DATA_W;

  // one directed step: a register write or a beat, with an optional fixed answer
  typedef struct {
    bit                  is_cfg;
    logic [IW-1:0]       cfg_idx;
    logic [DW-1:0]       cfg_val;
    ssbb_pkg::in_beat_t  beat;
    bit                  typed;
    ssbb_pkg::out_beat_t want;
  } step_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [IW-1:0]         cfg_idx_i;
  logic [DW-1:0]         cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  ssbb_pkg::in_beat_t    in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  ssbb_pkg::out_beat_t   out_data_o;

  // model copy of the registers and texture
  logic signed [10:0] org_x_q   = '0;
  logic signed [10:0] org_y_q   = '0;
  logic [9:0]         span_w_q  = 10'd64;
  logic [9:0]         span_h_q  = 10'd64;
  logic [8:0]         alpha_q   = ssbb_pkg::ALPHA_ONE;
  logic [31:0]        tex_mem    [TEX_ENTRIES];
  bit                 tex_loaded [TEX_ENTRIES];

  ssbb_pkg::out_beat_t pending_writes[$];
  bit        quiet_q = 1'b0;
  int        err_count    = 0;
  int        cycle_count  = 0;
  int        n_loads      = 0;
  int        n_reqs       = 0;
  int        n_writes     = 0;
  int        n_blends     = 0;
  int        n_cfg_writes = 0;

  scaled_sprite_blit_blend_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d writes outstanding", cycle_count,
               pending_writes.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    err_count++;
  endtask

  // ----- model -------------------------------------------------------------

  // texture slot a request reads, or -1 when it is clipped before the read
  function automatic int texel_slot(input ssbb_pkg::in_beat_t b, output int addr);
    int fx, fy, sx, sy;
    addr = 0;
    if (b.kind != ssbb_pkg::KIND_PIXEL) return -1;
    if (b.pixel_x >= span_w_q || b.pixel_y >= span_h_q) return -1;
    fx = int'(org_x_q) + int'(b.pixel_x);
    fy = int'(org_y_q) + int'(b.pixel_y);
    if (fx < 0 || fx >= SCR_W || fy < 0 || fy >= SCR_H) return -1;
    sx = int'(b.pixel_x) * TEX / int'(span_w_q);
    sy = int'(b.pixel_y) * TEX / int'(span_h_q);
    addr = fy * SCR_W + fx;
    return (sy * TEX + sx) % TEX_ENTRIES;
  endfunction

  function automatic logic [7:0] mix_chan(logic [7:0] s, logic [7:0] d, logic [8:0] a);
    int acc;
    acc = int'(d) * (256 - int'(a)) + int'(s) * int'(a);
    return 8'(acc >> 8);
  endfunction

  // framebuffer write a beat causes under the current registers
  function automatic ssbb_pkg::out_beat_t predict_write(ssbb_pkg::in_beat_t b);
    ssbb_pkg::out_beat_t r;
    int                  slot, addr;
    logic [31:0]         src, color;
    r = '0;
    slot = texel_slot(b, addr);
    if (slot < 0) return r;
    src = tex_mem[slot];
    // color key: fully transparent or too dark
    if ((src & ssbb_pkg::ALPHA_MASK) == '0 ||
        (src & ssbb_pkg::RGB_MASK) < ssbb_pkg::RGB_MIN) return r;
    if (alpha_q >= ssbb_pkg::ALPHA_ONE) begin
      color = src;
    end else begin
      color = {ssbb_pkg::ALPHA_OPAQUE,
               mix_chan(src[23:16], b.dest_pixel[23:16], alpha_q),
               mix_chan(src[15:8],  b.dest_pixel[15:8],  alpha_q),
               mix_chan(src[7:0],   b.dest_pixel[7:0],   alpha_q)};
    end
    r.write_enable  = 1'b1;
    r.write_address = 16'(addr);
    r.write_color   = color;
    return r;
  endfunction

  // ----- stimulus helpers --------------------------------------------------

  function automatic int draw_gap();
    return quiet_q ? 0 : int'($urandom_range(0, 10));
  endfunction

  function automatic int pick_span();
    case ($urandom_range(0, 19))
      0: return 0;
      1: return 1;
      2: return 1023;
      3: return 64;
      4: return 2;
      default: return int'($urandom_range(1, 160));
    endcase
  endfunction

  // sprite origin, mostly such that the sprite overlaps the screen
  function automatic int pick_origin(int span, int extent);
    int lo;
    case ($urandom_range(0, 9))
      0: return -1024;
      1: return 1023;
      2: return int'($urandom_range(0, 2047)) - 1024;
      default: begin
        lo = (span > 1) ? 1 - span : 0;
        if (lo < -1024) lo = -1024;
        return lo + int'($urandom_range(0, extent - 1 - lo));
      end
    endcase
  endfunction

  function automatic logic [9:0] pick_coord(logic [9:0] span);
    if (span != 0 && $urandom_range(0, 99) < 85)
      return 10'($urandom_range(0, int'(span) - 1));
    return 10'($urandom_range(0, 1023));
  endfunction

  // random beat, biased toward requests inside the sprite and keyed texels
  function automatic ssbb_pkg::in_beat_t random_beat();
    ssbb_pkg::in_beat_t b;
    b.kind        = ($urandom_range(0, 4) != 0) ? ssbb_pkg::KIND_PIXEL
                                                : ssbb_pkg::KIND_LOAD;
    b.texel_index = 12'($urandom_range(0, TEX_ENTRIES - 1));
    b.texel_value = $urandom;
    case ($urandom_range(0, 9))
      0: b.texel_value[31:24] = '0;
      1: b.texel_value[23:0]  = 24'($urandom_range(0, 'h080807));
      2: b.texel_value[23:0]  = ssbb_pkg::RGB_MIN[23:0];
      default: ;
    endcase
    b.pixel_x    = pick_coord(span_w_q);
    b.pixel_y    = pick_coord(span_h_q);
    b.dest_pixel = $urandom;
    return b;
  endfunction

  // send one beat, then record the write it must cause
  task automatic send_beat(ssbb_pkg::in_beat_t b, bit typed, ssbb_pkg::out_beat_t want);
    int                  gap;
    ssbb_pkg::out_beat_t exp;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    exp = predict_write(b);
    if (b.kind == ssbb_pkg::KIND_LOAD) begin
      n_loads++;
      if (int'(b.texel_index) < TEX_ENTRIES) begin
        tex_mem[b.texel_index]    = b.texel_value;
        tex_loaded[b.texel_index] = 1'b1;
      end
    end else begin
      n_reqs++;
    end
    if (exp.write_enable) begin
      n_writes++;
      if (alpha_q < ssbb_pkg::ALPHA_ONE) n_blends++;
    end
    pending_writes.push_back(typed ? want : exp);
  endtask

  // a request mapping onto an empty texel first gets that texel loaded
  task automatic issue(ssbb_pkg::in_beat_t b, bit typed, ssbb_pkg::out_beat_t want);
    int                 slot, addr;
    ssbb_pkg::in_beat_t fill;
    slot = texel_slot(b, addr);
    if (slot >= 0 && !tex_loaded[slot]) begin
      fill = random_beat();
      fill.kind = ssbb_pkg::KIND_LOAD;
      fill.texel_index = 12'(slot);
      send_beat(fill, 1'b0, '0);
    end
    send_beat(b, typed, want);
  endtask

  // hold the input until every write is back and the pipe has emptied
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 4) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [IW-1:0] idx, logic [DW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    n_cfg_writes++;
    case (idx)
      ssbb_pkg::CFG_DEST_X:      org_x_q  = val;
      ssbb_pkg::CFG_DEST_Y:      org_y_q  = val;
      ssbb_pkg::CFG_DEST_WIDTH:  span_w_q = val[9:0];
      ssbb_pkg::CFG_DEST_HEIGHT: span_h_q = val[9:0];
      ssbb_pkg::CFG_BLEND_ALPHA: alpha_q  = val[8:0];
      default: ;
    endcase
  endtask

  // directed table builders
  function automatic step_row_t cf(logic [IW-1:0] idx, int val);
    step_row_t r;
    r = '{default: '0};
    r.is_cfg  = 1'b1;
    r.cfg_idx = idx;
    r.cfg_val = DW'(val);
    return r;
  endfunction

  function automatic step_row_t ld(int idx, logic [31:0] val);
    step_row_t r;
    r = '{default: '0};
    r.beat.kind        = ssbb_pkg::KIND_LOAD;
    r.beat.texel_index = 12'(idx);
    r.beat.texel_value = val;
    r.typed = 1'b1;
    return r;
  endfunction

  function automatic step_row_t rq(int x, int y, logic [31:0] dst, bit typed = 1'b0,
                                   ssbb_pkg::out_beat_t want = '0);
    step_row_t r;
    r = '{default: '0};
    r.beat.kind       = ssbb_pkg::KIND_PIXEL;
    r.beat.pixel_x    = 10'(x);
    r.beat.pixel_y    = 10'(y);
    r.beat.dest_pixel = dst;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  function automatic ssbb_pkg::out_beat_t wr(int addr, logic [31:0] color);
    ssbb_pkg::out_beat_t r;
    r.write_enable  = 1'b1;
    r.write_address = 16'(addr);
    r.write_color   = color;
    return r;
  endfunction

  // ----- output side: random stalls and checking ---------------------------
  initial begin
    int                  stall;
    ssbb_pkg::out_beat_t exp;
    stall = 0;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i) begin
        if (pending_writes.size() == 0) begin
          report_mismatch($sformatf("beat with no write expected: %0b %h %h",
            out_data_o.write_enable, out_data_o.write_address, out_data_o.write_color));
        end else begin
          exp = pending_writes.pop_front();
          if (out_data_o.write_enable !== exp.write_enable)
            report_mismatch($sformatf("write_enable %b, want %b",
                                      out_data_o.write_enable, exp.write_enable));
          if (out_data_o.write_address !== exp.write_address)
            report_mismatch($sformatf("write_address %h, want %h",
                                      out_data_o.write_address, exp.write_address));
          if (out_data_o.write_color !== exp.write_color)
            report_mismatch($sformatf("write_color %h, want %h",
                                      out_data_o.write_color, exp.write_color));
        end
        stall = draw_gap();
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ----- input side --------------------------------------------------------
  initial begin
    step_row_t plan[$];
    int        span_w, span_h;

    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_wdata_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset registers, keyed texels, corners of sprite and screen
    plan.push_back(ld(0,    32'hFF12_3456));
    plan.push_back(ld(4095, 32'h80FF_FFFF));
    plan.push_back(ld(1,    32'h00FF_FFFF));
    plan.push_back(ld(2,    32'hFF08_0807));
    plan.push_back(ld(3,    32'hFF08_0808));
    plan.push_back(ld(2730, 32'hAAAA_AAAA));
    plan.push_back(ld(1365, 32'h5555_5555));
    plan.push_back(rq(0,  0,    32'hFFFF_FFFF, 1'b1, wr(0, 32'hFF12_3456)));
    plan.push_back(rq(63, 63,   32'h0000_0000, 1'b1, wr(20223, 32'h80FF_FFFF)));
    plan.push_back(rq(1,  0,    32'h1234_5678, 1'b1));
    plan.push_back(rq(2,  0,    32'h1234_5678, 1'b1));
    plan.push_back(rq(3,  0,    32'h1234_5678, 1'b1, wr(3, 32'hFF08_0808)));
    plan.push_back(rq(64, 0,    32'h1234_5678, 1'b1));
    plan.push_back(rq(0,  1023, 32'h1234_5678, 1'b1));
    // blend weights: half, none, just below one, above one
    plan.push_back(cf(ssbb_pkg::CFG_BLEND_ALPHA, 128));
    plan.push_back(rq(0, 0, 32'h0020_4060));
    plan.push_back(cf(ssbb_pkg::CFG_BLEND_ALPHA, 0));
    plan.push_back(rq(3, 0, 32'hAABB_CCDD));
    plan.push_back(cf(ssbb_pkg::CFG_BLEND_ALPHA, 255));
    plan.push_back(rq(63, 63, 32'h1234_5678));
    plan.push_back(cf(ssbb_pkg::CFG_BLEND_ALPHA, 511));
    plan.push_back(rq(0, 0, 32'h0102_0304, 1'b1, wr(0, 32'hFF12_3456)));
    // origin extremes and clipping at the screen edges
    plan.push_back(cf(ssbb_pkg::CFG_DEST_X, -1024));
    plan.push_back(rq(0, 0, 32'h0, 1'b1));
    plan.push_back(cf(ssbb_pkg::CFG_DEST_X, 1023));
    plan.push_back(rq(0, 0, 32'h0, 1'b1));
    plan.push_back(cf(ssbb_pkg::CFG_DEST_X, -63));
    plan.push_back(rq(63, 0, 32'hFFFF_FFFF));
    plan.push_back(cf(ssbb_pkg::CFG_DEST_Y, 136));
    plan.push_back(rq(63, 63, 32'hFFFF_FFFF));
    // widest sprite, shrunk onto the texture
    plan.push_back(cf(ssbb_pkg::CFG_DEST_WIDTH, 1023));
    plan.push_back(cf(ssbb_pkg::CFG_DEST_HEIGHT, 1023));
    plan.push_back(cf(ssbb_pkg::CFG_DEST_X, -1000));
    plan.push_back(cf(ssbb_pkg::CFG_DEST_Y, -1000));
    plan.push_back(rq(1022, 1022, 32'h0));
    // zero width never writes
    plan.push_back(cf(ssbb_pkg::CFG_DEST_WIDTH, 0));
    plan.push_back(rq(0, 0, 32'h0, 1'b1));
    // one-pixel sprite at the last screen address
    plan.push_back(cf(ssbb_pkg::CFG_DEST_WIDTH, 1));
    plan.push_back(cf(ssbb_pkg::CFG_DEST_HEIGHT, 1));
    plan.push_back(cf(ssbb_pkg::CFG_DEST_X, SCR_W - 1));
    plan.push_back(cf(ssbb_pkg::CFG_DEST_Y, SCR_H - 1));
    plan.push_back(rq(0, 0, 32'h0, 1'b1, wr(SCR_W * SCR_H - 1, 32'hFF12_3456)));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_idle();
        write_cfg(plan[i].cfg_idx, plan[i].cfg_val);
        cfg_we_i <= 1'b0;
      end else begin
        issue(plan[i].beat, plan[i].typed, plan[i].want);
      end
    end

    // random phases, each with a new register setting written while idle
    while (n_loads + n_reqs < ITEM_TARGET) begin
      span_w = pick_span();
      span_h = pick_span();
      wait_idle();
      write_cfg(ssbb_pkg::CFG_DEST_X,      DW'(pick_origin(span_w, SCR_W)));
      write_cfg(ssbb_pkg::CFG_DEST_Y,      DW'(pick_origin(span_h, SCR_H)));
      write_cfg(ssbb_pkg::CFG_DEST_WIDTH,  DW'(span_w));
      write_cfg(ssbb_pkg::CFG_DEST_HEIGHT, DW'(span_h));
      case ($urandom_range(0, 9))
        0, 1, 2: write_cfg(ssbb_pkg::CFG_BLEND_ALPHA, DW'(ssbb_pkg::ALPHA_ONE));
        3:       write_cfg(ssbb_pkg::CFG_BLEND_ALPHA, '0);
        4:       write_cfg(ssbb_pkg::CFG_BLEND_ALPHA, DW'($urandom_range(257, 511)));
        5:       write_cfg(ssbb_pkg::CFG_BLEND_ALPHA, DW'(255));
        default: write_cfg(ssbb_pkg::CFG_BLEND_ALPHA, DW'($urandom_range(1, 255)));
      endcase
      cfg_we_i <= 1'b0;
      // some phases run back to back on both sides
      quiet_q = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(40, 120)) issue(random_beat(), 1'b0, '0);
    end

    wait_idle();
    $display("covered %0d texel loads and %0d pixel requests over %0d register writes",
             n_loads, n_reqs, n_cfg_writes);
    $display("%0d framebuffer writes expected, %0d blended, %0d mismatches",
             n_writes, n_blends, err_count);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
